// ===== rtl/cticr_pkg.sv =====
// shared types, codes and constants for the timer and interrupt controller
// no dependencies
`default_nettype none

package cticr_pkg;

	// item kinds
	localparam logic [2:0] MODE_READ  = 3'd0;
	localparam logic [2:0] MODE_WRITE = 3'd1;
	localparam logic [2:0] MODE_TICK  = 3'd2;
	localparam logic [2:0] MODE_POLL  = 3'd3;
	localparam logic [2:0] MODE_TAKE  = 3'd4;

	// page regions, address bits 12..10
	localparam logic [2:0] REGION_SOUND = 3'd2;
	localparam logic [2:0] REGION_TIMER = 3'd3;
	localparam logic [2:0] REGION_PORT  = 3'd4;
	localparam logic [2:0] REGION_IRQ   = 3'd5;

	// interrupt region registers, address bits 1..0
	localparam logic [1:0] IRQ_REG_ENABLE  = 2'd2;
	localparam logic [1:0] IRQ_REG_REQUEST = 2'd3;

	// taken source codes
	localparam logic [1:0] SRC_NONE  = 2'd0;
	localparam logic [1:0] SRC_TIMER = 2'd1;
	localparam logic [1:0] SRC_IRQ1  = 2'd2;
	localparam logic [1:0] SRC_IRQ2  = 2'd3;

	// request and enable bit positions
	localparam int BIT_TIMER = 2;
	localparam int BIT_IRQ1  = 1;
	localparam int BIT_IRQ2  = 0;

	localparam logic [7:0] RDATA_UNMAPPED  = 8'hFF;
	localparam logic [3:0] PORT_FIXED_HIGH = 4'h3;

	typedef struct packed {
		logic [2:0]  mode;
		logic [12:0] addr;
		logic [7:0]  wdata;
		logic        irq1_req;
		logic        irq2_req;
		logic        cpu_irq_masked;
		logic [3:0]  port_in;
		logic        bus_blocked;
	} item_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       port_write_valid;
		logic [1:0] port_out;
		logic       irq_pending;
		logic [1:0] irq_source;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/cticr_exec.sv =====
// timer, interrupt mask, request latch and bus buffer state with the
// combinational next-state update for one request; depends on cticr_pkg
`default_nettype none

module cticr_exec
	import cticr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    fire,
	input  wire item_t   item,
	output      result_t res
);

	logic [6:0] count_q, count_d;
	logic [6:0] reload_q, reload_d;
	logic       running_q, running_d;
	logic [7:0] last_q, last_d;
	logic [2:0] enable_q, enable_d;
	logic       treq_q, treq_d;
	logic [2:0] polled_q, polled_d;
	logic       decided_q, decided_d;

	logic [2:0] live;
	logic [2:0] region;
	logic [1:0] reg_sel;
	logic [2:0] hit;

	assign live    = {treq_q, item.irq1_req, item.irq2_req};
	assign region  = item.addr[12:10];
	assign reg_sel = item.addr[1:0];
	assign hit     = enable_q & polled_q;

	// next state and result for the current request
	always_comb begin
		count_d   = count_q;
		reload_d  = reload_q;
		running_d = running_q;
		last_d    = last_q;
		enable_d  = enable_q;
		treq_d    = treq_q;
		polled_d  = polled_q;
		decided_d = decided_q;
		res.rdata            = '0;
		res.port_write_valid = 1'b0;
		res.port_out         = '0;
		res.irq_source       = SRC_NONE;

		unique case (item.mode)
			MODE_READ: begin
				unique case (region)
					REGION_SOUND: res.rdata = item.bus_blocked ? 8'h00 : last_q;
					REGION_TIMER: res.rdata = item.bus_blocked ? 8'h00 : {last_q[7], count_q};
					REGION_PORT:  res.rdata = item.bus_blocked ? 8'h00 :
						{PORT_FIXED_HIGH, item.port_in};
					REGION_IRQ: begin
						if (item.bus_blocked) begin
							res.rdata = 8'h00;
						end else if (reg_sel == IRQ_REG_ENABLE) begin
							res.rdata = {last_q[7:3], ~enable_q};
						end else if (reg_sel == IRQ_REG_REQUEST) begin
							res.rdata = {last_q[7:3], live};
						end else begin
							res.rdata = last_q;
						end
					end
					default: res.rdata = RDATA_UNMAPPED;
				endcase
			end
			MODE_WRITE: begin
				unique case (region)
					REGION_TIMER: begin
						last_d = item.wdata;
						if (!item.addr[0]) begin
							reload_d = item.wdata[6:0];
						end else begin
							// start from stopped loads the count
							if (!running_q && item.wdata[0]) count_d = reload_q;
							running_d = item.wdata[0];
						end
					end
					REGION_PORT: begin
						last_d               = item.wdata;
						res.port_write_valid = 1'b1;
						res.port_out         = item.wdata[1:0];
					end
					REGION_IRQ: begin
						last_d = item.wdata;
						if (reg_sel == IRQ_REG_ENABLE) enable_d = ~item.wdata[2:0];
						else if (reg_sel == IRQ_REG_REQUEST) treq_d = 1'b0;
					end
					default: ;
				endcase
			end
			MODE_TICK: begin
				if (running_q) begin
					if (count_q == 7'd0) begin
						count_d = reload_q;
						treq_d  = 1'b1;
					end else begin
						count_d = count_q - 7'd1;
					end
				end
			end
			MODE_POLL: begin
				polled_d  = live;
				decided_d = (|(enable_q & live)) && !item.cpu_irq_masked;
			end
			MODE_TAKE: begin
				if (decided_q) begin
					decided_d = 1'b0;
					priority if (hit[BIT_TIMER]) begin
						treq_d         = 1'b0;
						res.irq_source = SRC_TIMER;
					end else if (hit[BIT_IRQ1]) begin
						res.irq_source = SRC_IRQ1;
					end else if (hit[BIT_IRQ2]) begin
						res.irq_source = SRC_IRQ2;
					end else begin
						res.irq_source = SRC_NONE;
					end
				end
			end
			default: ;
		endcase

		res.irq_pending = decided_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			reload_q  <= '0;
			running_q <= 1'b0;
			last_q    <= '0;
			enable_q  <= '0;
			treq_q    <= 1'b0;
			polled_q  <= '0;
			decided_q <= 1'b0;
		end else if (fire) begin
			count_q   <= count_d;
			reload_q  <= reload_d;
			running_q <= running_d;
			last_q    <= last_d;
			enable_q  <= enable_d;
			treq_q    <= treq_d;
			polled_q  <= polled_d;
			decided_q <= decided_d;
		end
	end

	// a take always clears the decision
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_TAKE |=> !decided_q)
		else $error("decision survived a take");

	// taking the timer source drops its request
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.irq_source == SRC_TIMER |=> !treq_q)
		else $error("timer request kept after it was taken");

	// a masked poll never decides
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_POLL && item.cpu_irq_masked |=> !decided_q)
		else $error("masked poll decided an interrupt");

	// a source is only reported when a decision existed
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.irq_source != SRC_NONE |-> decided_q)
		else $error("source taken without a decision");

endmodule

`default_nettype wire

// ===== rtl/cpu_timer_interrupt_controller_core.sv =====
// Timer and interrupt controller of an 8-bit CPU I/O page. One request (read,
// write, tick, poll or take) is accepted per clock while in_stall is low; each
// gives one result through the input register, the state update and the result
// register. A stalled result does not block the next request
// until the input register is also occupied. Depends on cticr_pkg, cticr_exec.
`default_nettype none

module cpu_timer_interrupt_controller_core
	import cticr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [12:0] addr,
	input  wire logic [7:0]  wdata,
	input  wire logic        irq1_req,
	input  wire logic        irq2_req,
	input  wire logic        cpu_irq_masked,
	input  wire logic [3:0]  port_in,
	input  wire logic        bus_blocked,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [7:0]  rdata,
	output      logic        port_write_valid,
	output      logic [1:0]  port_out,
	output      logic        irq_pending,
	output      logic [1:0]  irq_source
);

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t res;
	result_t res_q;

	// input stage moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{mode: mode, addr: addr, wdata: wdata, irq1_req: irq1_req,
				irq2_req: irq2_req, cpu_irq_masked: cpu_irq_masked,
				port_in: port_in, bus_blocked: bus_blocked};
		end
	end

	cticr_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign rdata            = res_q.rdata;
	assign port_write_valid = res_q.port_write_valid;
	assign port_out         = res_q.port_out;
	assign irq_pending      = res_q.irq_pending;
	assign irq_source       = res_q.irq_source;

	// the input side only stalls behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a held result");

	// a request that moves on always produces a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result lost after advance");

endmodule

`default_nettype wire

// ===== verif/tb_cpu_timer_interrupt_controller_core.sv =====
`timescale 1ns / 1ps
// testbench for the cpu timer and interrupt controller core: directed and random requests,
// predicted results checked field by field against the block's output channel
// depends on cticr_pkg and cpu_timer_interrupt_controller_core

module tb_cpu_timer_interrupt_controller_core
	import cticr_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int          HOLD_OFF_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = '0;
	logic [12:0] addr = '0;
	logic [7:0]  wdata = '0;
	logic        irq1_req = 1'b0;
	logic        irq2_req = 1'b0;
	logic        cpu_irq_masked = 1'b0;
	logic [3:0]  port_in = '0;
	logic        bus_blocked = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  rdata;
	logic        port_write_valid;
	logic [1:0]  port_out;
	logic        irq_pending;
	logic [1:0]  irq_source;

	// predicted controller state
	logic [6:0] tmr_count = '0;
	logic [6:0] tmr_reload = '0;
	logic       tmr_running = 1'b0;
	logic [7:0] bus_latch = '0;
	logic [2:0] irq_enable = '0;
	logic       tmr_irq = 1'b0;
	logic [2:0] polled_req = '0;
	logic       irq_decided = 1'b0;

	result_t     predicted_results[$];
	int          errors = 0;
	int          sent_count = 0;
	int          checked_count = 0;
	int          mode_count[8];
	int          timer_takes = 0;
	int unsigned cycle_count = 0;
	bit          no_idle = 1'b0;
	int          hold_request = 0;

	cpu_timer_interrupt_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.addr(addr),
		.wdata(wdata),
		.irq1_req(irq1_req),
		.irq2_req(irq2_req),
		.cpu_irq_masked(cpu_irq_masked),
		.port_in(port_in),
		.bus_blocked(bus_blocked),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rdata(rdata),
		.port_write_valid(port_write_valid),
		.port_out(port_out),
		.irq_pending(irq_pending),
		.irq_source(irq_source)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// next state and result of the controller for one request
	function automatic result_t predict_controller(item_t req);
		result_t    res;
		logic [2:0] region;
		logic [2:0] live;
		logic [2:0] hit;
		res = '0;
		region = req.addr[12:10];
		live = '0;
		live[BIT_TIMER] = tmr_irq;
		live[BIT_IRQ1] = req.irq1_req;
		live[BIT_IRQ2] = req.irq2_req;
		case (req.mode)
			MODE_READ: begin
				case (region)
					REGION_SOUND: res.rdata = bus_latch;
					REGION_TIMER: res.rdata = {bus_latch[7], tmr_count};
					REGION_PORT:  res.rdata = {PORT_FIXED_HIGH, req.port_in};
					REGION_IRQ: begin
						if (req.addr[1:0] == IRQ_REG_ENABLE)
							res.rdata = {bus_latch[7:3], ~irq_enable};
						else if (req.addr[1:0] == IRQ_REG_REQUEST)
							res.rdata = {bus_latch[7:3], live};
						else
							res.rdata = bus_latch;
					end
					default: res.rdata = RDATA_UNMAPPED;
				endcase
				// blocking only hides the mapped regions
				if (req.bus_blocked && region >= REGION_SOUND && region <= REGION_IRQ)
					res.rdata = '0;
			end
			MODE_WRITE: begin
				case (region)
					REGION_TIMER: begin
						bus_latch = req.wdata;
						if (!req.addr[0]) begin
							tmr_reload = req.wdata[6:0];
						end else begin
							if (!tmr_running && req.wdata[0])
								tmr_count = tmr_reload;
							tmr_running = req.wdata[0];
						end
					end
					REGION_PORT: begin
						bus_latch = req.wdata;
						res.port_write_valid = 1'b1;
						res.port_out = req.wdata[1:0];
					end
					REGION_IRQ: begin
						bus_latch = req.wdata;
						if (req.addr[1:0] == IRQ_REG_ENABLE)
							irq_enable = ~req.wdata[2:0];
						else if (req.addr[1:0] == IRQ_REG_REQUEST)
							tmr_irq = 1'b0;
					end
					default: ;
				endcase
			end
			MODE_TICK: begin
				if (tmr_running) begin
					if (tmr_count == '0) begin
						tmr_count = tmr_reload;
						tmr_irq = 1'b1;
					end else begin
						tmr_count = tmr_count - 7'd1;
					end
				end
			end
			MODE_POLL: begin
				irq_decided = ((irq_enable & live) != '0) && !req.cpu_irq_masked;
				polled_req = live;
			end
			MODE_TAKE: begin
				if (irq_decided) begin
					irq_decided = 1'b0;
					hit = irq_enable & polled_req;
					if (hit[BIT_TIMER]) begin
						tmr_irq = 1'b0;
						res.irq_source = SRC_TIMER;
					end else if (hit[BIT_IRQ1]) begin
						res.irq_source = SRC_IRQ1;
					end else if (hit[BIT_IRQ2]) begin
						res.irq_source = SRC_IRQ2;
					end else begin
						res.irq_source = SRC_NONE;
					end
				end
			end
			default: ;
		endcase
		res.irq_pending = irq_decided;
		return res;
	endfunction

	function automatic item_t make_request(logic [2:0] kind, logic [2:0] region,
			logic [1:0] reg_sel, logic [7:0] data);
		item_t req;
		req = '0;
		req.mode = kind;
		req.addr = {region, 8'h00, reg_sel};
		req.wdata = data;
		return req;
	endfunction

	function automatic item_t random_request();
		item_t req;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			req.mode = MODE_READ;
		else if (pick < 60)
			req.mode = MODE_WRITE;
		else if (pick < 75)
			req.mode = MODE_TICK;
		else if (pick < 85)
			req.mode = MODE_POLL;
		else if (pick < 95)
			req.mode = MODE_TAKE;
		else
			req.mode = 3'($urandom_range(MODE_TAKE + 1, 7));
		req.addr = 13'($urandom);
		if ($urandom_range(0, 9) < 7)
			req.addr[12:10] = 3'($urandom_range(REGION_SOUND, REGION_IRQ));
		req.wdata = 8'($urandom);
		req.irq1_req = 1'($urandom);
		req.irq2_req = 1'($urandom);
		req.cpu_irq_masked = ($urandom_range(0, 3) == 0);
		req.port_in = 4'($urandom);
		req.bus_blocked = ($urandom_range(0, 4) == 0);
		return req;
	endfunction

	// offer one request, hold it until accepted, then predict its result
	task automatic send_request(input item_t req);
		int gap;
		gap = no_idle ? 0 : pick_idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= req.mode;
		addr <= req.addr;
		wdata <= req.wdata;
		irq1_req <= req.irq1_req;
		irq2_req <= req.irq2_req;
		cpu_irq_masked <= req.cpu_irq_masked;
		port_in <= req.port_in;
		bus_blocked <= req.bus_blocked;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted_results.push_back(predict_controller(req));
		sent_count++;
		mode_count[req.mode]++;
	endtask

	// receiver: check each accepted result, then choose the next stall
	always @(posedge clk) begin : result_check
		result_t want;
		int      hold_left;
		int      stall_left;
		if (out_valid && !out_stall) begin
			checked_count++;
			if (predicted_results.size() == 0) begin
				$error("result with nothing predicted");
				errors++;
			end else begin
				want = predicted_results.pop_front();
				if (rdata !== want.rdata) begin
					$error("rdata: expected %0h, got %0h", want.rdata, rdata);
					errors++;
				end
				if (port_write_valid !== want.port_write_valid) begin
					$error("port_write_valid: expected %0d, got %0d",
						want.port_write_valid, port_write_valid);
					errors++;
				end
				if (port_out !== want.port_out) begin
					$error("port_out: expected %0d, got %0d", want.port_out, port_out);
					errors++;
				end
				if (irq_pending !== want.irq_pending) begin
					$error("irq_pending: expected %0d, got %0d", want.irq_pending, irq_pending);
					errors++;
				end
				if (irq_source !== want.irq_source) begin
					$error("irq_source: expected %0d, got %0d", want.irq_source, irq_source);
					errors++;
				end
				if (want.irq_source == SRC_TIMER)
					timer_takes++;
			end
		end
		// a long hold-off overrides the random stalls
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = no_idle ? 0 : pick_idle_len();
		end
	end

	// register reads and writes across mapped and unmapped regions, timer programming and extremes
	task automatic test_register_access();
		item_t req;
		send_request(make_request(MODE_READ, REGION_TIMER, 2'd0, 8'h00));
		send_request(make_request(MODE_WRITE, REGION_TIMER, 2'd0, 8'hFF));
		send_request(make_request(MODE_WRITE, REGION_TIMER, 2'd1, 8'h01));
		req = make_request(MODE_READ, REGION_TIMER, 2'd1, 8'h00);
		req.bus_blocked = 1'b1;
		send_request(req);
		send_request(make_request(MODE_READ, REGION_SOUND, 2'd0, 8'h00));
		// sound writes go nowhere
		send_request(make_request(MODE_WRITE, REGION_SOUND, 2'd3, 8'h5A));
		send_request(make_request(MODE_WRITE, REGION_PORT, 2'd0, 8'hFF));
		req = make_request(MODE_READ, REGION_PORT, 2'd0, 8'h00);
		req.port_in = 4'hF;
		send_request(req);
		// unmapped and absent regions, even with blocking
		req = make_request(MODE_READ, 3'd0, 2'd3, 8'h00);
		req.addr = 13'h03FF;
		req.bus_blocked = 1'b1;
		send_request(req);
		req = make_request(MODE_READ, 3'd7, 2'd3, 8'h00);
		req.addr = 13'h1FFF;
		send_request(req);
		send_request(make_request(MODE_WRITE, 3'd6, 2'd0, 8'h00));
		send_request(make_request(MODE_READ, REGION_IRQ, 2'd0, 8'h00));
		// tick while stopped leaves the count alone
		send_request(make_request(MODE_WRITE, REGION_TIMER, 2'd1, 8'h00));
		send_request(make_request(MODE_TICK, 3'd0, 2'd0, 8'h00));
	endtask

	// poll and take paths, priority and clearing of the timer request
	task automatic test_interrupt_paths();
		item_t req;
		send_request(make_request(MODE_WRITE, REGION_IRQ, IRQ_REG_ENABLE, 8'h00));
		send_request(make_request(MODE_WRITE, REGION_TIMER, 2'd0, 8'h00));
		send_request(make_request(MODE_WRITE, REGION_TIMER, 2'd1, 8'h01));
		// tick at zero reloads and raises the timer request
		send_request(make_request(MODE_TICK, 3'd0, 2'd0, 8'h00));
		req = make_request(MODE_READ, REGION_IRQ, IRQ_REG_REQUEST, 8'h00);
		req.irq1_req = 1'b1;
		req.irq2_req = 1'b1;
		send_request(req);
		req.mode = MODE_POLL;
		req.cpu_irq_masked = 1'b1;
		send_request(req);
		// take with nothing decided
		send_request(make_request(MODE_TAKE, 3'd0, 2'd0, 8'h00));
		req.cpu_irq_masked = 1'b0;
		send_request(req);
		send_request(make_request(MODE_TAKE, 3'd0, 2'd0, 8'h00));
		send_request(req);
		send_request(make_request(MODE_TAKE, 3'd0, 2'd0, 8'h00));
		// decision stands but enables were dropped before the take
		req.irq1_req = 1'b0;
		send_request(req);
		send_request(make_request(MODE_WRITE, REGION_IRQ, IRQ_REG_ENABLE, 8'h07));
		send_request(make_request(MODE_TAKE, 3'd0, 2'd0, 8'h00));
		send_request(make_request(MODE_WRITE, REGION_IRQ, IRQ_REG_REQUEST, 8'hA5));
		send_request(make_request(MODE_WRITE, REGION_IRQ, 2'd1, 8'h3C));
		// unknown kind with every other field high
		req = '1;
		send_request(req);
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_request(random_request());
	endtask

	// program enables and timer, tick it down, then poll and take
	task automatic test_timer_irq_sequences(input int count);
		item_t      req;
		int         first;
		int         n_ticks;
		logic [6:0] reload;
		first = sent_count;
		while (sent_count - first < count) begin
			if ($urandom_range(0, 3) == 0)
				send_request(make_request(MODE_WRITE, REGION_IRQ, IRQ_REG_ENABLE, 8'($urandom)));
			else
				send_request(make_request(MODE_WRITE, REGION_IRQ, IRQ_REG_ENABLE,
					8'($urandom) & 8'hF8));
			reload = ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6));
			send_request(make_request(MODE_WRITE, REGION_TIMER, 2'd0,
				{1'($urandom), reload}));
			send_request(make_request(MODE_WRITE, REGION_TIMER, 2'd1, 8'($urandom) | 8'h01));
			n_ticks = $urandom_range(0, int'(reload) + 3);
			repeat (n_ticks) begin
				req = make_request(MODE_TICK, 3'($urandom), 2'($urandom), 8'($urandom));
				if ($urandom_range(0, 7) == 0)
					req = make_request(MODE_READ, REGION_TIMER, 2'($urandom), 8'h00);
				send_request(req);
			end
			if ($urandom_range(0, 4) == 0)
				send_request(random_request());
			req = make_request(MODE_POLL, 3'($urandom), 2'($urandom), 8'($urandom));
			req.addr[9:2] = 8'($urandom);
			req.irq1_req = 1'($urandom);
			req.irq2_req = 1'($urandom);
			req.cpu_irq_masked = ($urandom_range(0, 4) == 0);
			send_request(req);
			if ($urandom_range(0, 2) == 0) begin
				req.mode = MODE_READ;
				req.addr = {REGION_IRQ, 8'($urandom), IRQ_REG_REQUEST};
				req.bus_blocked = ($urandom_range(0, 5) == 0);
				send_request(req);
			end
			send_request(make_request(MODE_TAKE, 3'($urandom), 2'($urandom), 8'($urandom)));
			if ($urandom_range(0, 2) == 0)
				send_request(make_request(MODE_WRITE, REGION_IRQ, IRQ_REG_REQUEST,
					8'($urandom)));
			if ($urandom_range(0, 3) == 0)
				send_request(make_request(MODE_WRITE, REGION_TIMER, 2'd1,
					8'($urandom) & 8'hFE));
		end
	endtask

	// back to back with no gaps on either side
	task automatic test_no_idle_stretch(input int count);
		no_idle = 1'b1;
		repeat (count) send_request(random_request());
		no_idle = 1'b0;
	endtask

	// receiver holds off while the sender keeps pushing, filling the block
	task automatic test_back_pressure(input int count);
		no_idle = 1'b1;
		hold_request = HOLD_OFF_CYCLES;
		repeat (count) send_request(random_request());
		no_idle = 1'b0;
	endtask

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_cpu_timer_interrupt_controller_core NOT OK");
		$finish;
	end

	initial begin : run_tests
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_interrupt_paths();
		test_random_mix(550);
		test_timer_irq_sequences(650);
		test_no_idle_stretch(150);
		test_back_pressure(100);
		test_random_mix(100);

		in_valid <= 1'b0;
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d requests: %0d reads, %0d writes, %0d ticks, %0d polls, %0d takes",
			sent_count, mode_count[MODE_READ], mode_count[MODE_WRITE], mode_count[MODE_TICK],
			mode_count[MODE_POLL], mode_count[MODE_TAKE]);
		$display("%0d results checked, %0d timer interrupts taken, %0d cycles",
			checked_count, timer_takes, cycle_count);
		if (errors == 0)
			$display("tb_cpu_timer_interrupt_controller_core OK");
		else
			$display("tb_cpu_timer_interrupt_controller_core NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cticr_pkg.sv
rtl/cticr_exec.sv
rtl/cpu_timer_interrupt_controller_core.sv
verif/tb_cpu_timer_interrupt_controller_core.sv
